FILE: hdl/calendar_day_difference_unit_macros.svh
// assertion macros for the calendar day difference unit
// used by the top level only; expects clk and rst_n in scope
`ifndef CALENDAR_DAY_DIFFERENCE_UNIT_MACROS_SVH
`define CALENDAR_DAY_DIFFERENCE_UNIT_MACROS_SVH

// same-cycle implication
`define CDD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdd assertion failed");

// next-cycle implication
`define CDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdd assertion failed");

`endif

FILE: hdl/cdd_pkg.sv
// shared constants, types and the month table of the day difference unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cdd_pkg;

  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int DIFF_W    = 22;
  localparam int MTERM_W   = 9;
  localparam int YEAR_DAYS = 365;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

  // stage load enables for one date's day number pipe
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  // days in a common year before month m; month 0 counts none, 13..15 a full year
  function automatic logic [MTERM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [MTERM_W-1:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cdd_day_number.sv
// two register stages that turn one date into its day number
// depends on cdd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cdd_day_number #(
  parameter int YEAR_BITS = 12,
  parameter int DN_W      = YEAR_BITS + 10
) (
  input  wire logic                        clk,
  input  wire cdd_pkg::stage_en_t          en,
  input  wire logic [YEAR_BITS-1:0]        year,
  input  wire logic [cdd_pkg::MONTH_W-1:0] month,
  input  wire logic [cdd_pkg::DAY_W-1:0]   day,
  output logic [DN_W-1:0]                  day_num
);

  localparam int LC_W = YEAR_BITS - 1;

  logic [DN_W-1:0]             y365_r, y365_nxt;
  logic [LC_W-1:0]             leap_cnt_r, leap_cnt_nxt;
  logic [cdd_pkg::MTERM_W-1:0] mterm_r, mterm_nxt;
  logic [DN_W-1:0]             dn_r, dn_nxt;
  logic [YEAR_BITS:0]          y_plus3;
  logic                        leap;

  // stage 1: whole years, leap years before, months before plus day
  always_comb begin
    y365_nxt     = DN_W'(year) * DN_W'(cdd_pkg::YEAR_DAYS);
    y_plus3      = {1'b0, year} + (YEAR_BITS+1)'(3);
    leap_cnt_nxt = y_plus3[YEAR_BITS:2];
    leap         = (year[1:0] == 2'b00);
    mterm_nxt    = cdd_pkg::days_before_month(month)
                 + cdd_pkg::MTERM_W'(leap && (month > cdd_pkg::MONTH_FEB))
                 + cdd_pkg::MTERM_W'(day);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y365_r     <= y365_nxt;
      leap_cnt_r <= leap_cnt_nxt;
      mterm_r    <= mterm_nxt;
    end
  end

  // stage 2: sum of the three terms
  assign dn_nxt = y365_r + DN_W'(leap_cnt_r) + DN_W'(mterm_r);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      dn_r <= dn_nxt;
    end
  end

  assign day_num = dn_r;

endmodule

`default_nettype wire

FILE: hdl/calendar_day_difference_unit.sv
// Calendar day difference unit: signed days from a reference date to a
// measured date, years divisible by four are leap years.
// Input channel in_valid/in_ready carries one beat of two dates (year,
// month, day each); output channel out_valid/out_ready carries one beat of
// out_day_difference, 22-bit two's complement (first minus second).
// An accepted input beat reaches out_valid through three register stages
// (year/month terms, day number sum, subtraction).
// Throughput: one beat per cycle while the output is not blocked; the
// constant multiply by 365 and the three-term add set the stage depth.
// Each stage holds a valid bit and advances whenever the stage after it is
// empty or advancing, so bubbles are squeezed out while out_ready is low
// and up to three beats sit inside before in_ready drops.
// Reset (rst_n low, synchronous) clears the valid bits only; the block
// keeps no state between beats and needs no configuration.
// Depends on cdd_pkg, cdd_day_number and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "calendar_day_difference_unit_macros.svh"

module calendar_day_difference_unit #(
  parameter int YEAR_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [YEAR_BITS-1:0]        in_first_year,
  input  wire logic [cdd_pkg::MONTH_W-1:0] in_first_month,
  input  wire logic [cdd_pkg::DAY_W-1:0]   in_first_day,
  input  wire logic [YEAR_BITS-1:0]        in_second_year,
  input  wire logic [cdd_pkg::MONTH_W-1:0] in_second_month,
  input  wire logic [cdd_pkg::DAY_W-1:0]   in_second_day,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [cdd_pkg::DIFF_W-1:0] out_day_difference
);

  localparam int DN_W = YEAR_BITS + 10;

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic adv1, adv2, adv3;
  cdd_pkg::stage_en_t en;
  logic [DN_W-1:0] dn_first, dn_second;
  logic signed [DN_W:0] diff_wide;
  logic signed [cdd_pkg::DIFF_W-1:0] diff_r, diff_nxt;

  // per-stage advance, backpressure ripples from the output
  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  assign en = '{s1: adv1 && in_valid, s2: adv2 && v1_r};

  // valid bits travel with the beat
  always_comb begin
    v1_nxt = adv1 ? in_valid : v1_r;
    v2_nxt = adv2 ? v1_r     : v2_r;
    v3_nxt = adv3 ? v2_r     : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // day numbers of both dates
  cdd_day_number #(.YEAR_BITS(YEAR_BITS), .DN_W(DN_W)) u_dn_first (
    .clk     (clk),
    .en      (en),
    .year    (in_first_year),
    .month   (in_first_month),
    .day     (in_first_day),
    .day_num (dn_first)
  );

  cdd_day_number #(.YEAR_BITS(YEAR_BITS), .DN_W(DN_W)) u_dn_second (
    .clk     (clk),
    .en      (en),
    .year    (in_second_year),
    .month   (in_second_month),
    .day     (in_second_day),
    .day_num (dn_second)
  );

  // stage 3: subtraction, wrapped or sign extended to the result width
  assign diff_wide = $signed({1'b0, dn_first}) - $signed({1'b0, dn_second});
  assign diff_nxt  = cdd_pkg::DIFF_W'(diff_wide);

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      diff_r <= diff_nxt;
    end
  end

  assign out_valid          = v3_r;
  assign out_day_difference = diff_r;

  // accepted beat lands in stage 1
  `CDD_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v1_r)
  // input stalls only when every stage is full and the output is blocked
  `CDD_ASSERT_NOW(a_stall_only_full, !in_ready, v1_r && v2_r && v3_r && !out_ready)
  // a blocked stage 2 keeps its beat and day numbers
  `CDD_ASSERT_NEXT(a_s2_holds, v2_r && v3_r && !out_ready,
                   v2_r && $stable(dn_first) && $stable(dn_second))

endmodule

`default_nettype wire

FILE: dv/calendar_day_difference_unit_tb.sv
// testbench for the calendar day difference unit: directed and random date pairs,
// random idling on both channels, results checked against a day number predictor
// depends on cdd_pkg and calendar_day_difference_unit
`timescale 1ns / 1ps

module calendar_day_difference_unit_tb;

  localparam int YEAR_BITS    = 12;
  localparam int MONTH_W      = cdd_pkg::MONTH_W;
  localparam int DAY_W        = cdd_pkg::DAY_W;
  localparam int DIFF_W       = cdd_pkg::DIFF_W;
  localparam int RANDOM_BEATS = 1950;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic [YEAR_BITS-1:0] year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
  } date_t;

  typedef struct packed {
    date_t                     measured;
    date_t                     reference;
    logic signed [DIFF_W-1:0]  days;
  } owed_diff_t;

  // tracks owed day differences in arrival order and checks each output beat
  class day_diff_scoreboard;
    owed_diff_t owed_diffs[$];
    int         mismatches = 0;

    // day number of a date; the table holds days before each month in a common year, 13..15 a full year
    function automatic int date_number(date_t dt);
      int cum[16] = '{0, 0, 31, 59, 90, 120, 151, 181,
                      212, 243, 273, 304, 334, 365, 365, 365};
      int y;
      int m;
      int n;
      y = int'(dt.year);
      m = int'(dt.month);
      n = 365 * y + (y + 3) / 4 + cum[m] + int'(dt.day);
      // leap day counts once february is past
      if ((y % 4) == 0 && m > 2)
        n = n + 1;
      return n;
    endfunction

    task note_dates(date_t measured, date_t reference);
      owed_diff_t od;
      od.measured  = measured;
      od.reference = reference;
      od.days      = DIFF_W'(date_number(measured) - date_number(reference));
      owed_diffs   = {owed_diffs, od};
    endtask

    task report(string what, owed_diff_t od, logic signed [DIFF_W-1:0] got);
      if (mismatches < PRINT_CAP)
        $display("MISMATCH %s: %0d/%0d/%0d minus %0d/%0d/%0d wanted %0d got %0d",
                 what, od.measured.year, od.measured.month, od.measured.day,
                 od.reference.year, od.reference.month, od.reference.day,
                 od.days, got);
      mismatches++;
    endtask

    task check_difference(logic signed [DIFF_W-1:0] got);
      owed_diff_t od;
      if (owed_diffs.size() == 0) begin
        od = '0;
        report("unexpected beat", od, got);
      end else begin
        od = owed_diffs.pop_front();
        if (got !== od.days)
          report("day_difference", od, got);
      end
    endtask

    function int pending();
      return owed_diffs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [YEAR_BITS-1:0] in_first_year;
  logic [MONTH_W-1:0]   in_first_month;
  logic [DAY_W-1:0]     in_first_day;
  logic [YEAR_BITS-1:0] in_second_year;
  logic [MONTH_W-1:0]   in_second_month;
  logic [DAY_W-1:0]     in_second_day;
  logic out_valid;
  logic out_ready;
  logic signed [DIFF_W-1:0] out_day_difference;

  day_diff_scoreboard sb = new();
  int  beats_in   = 0;
  int  send_burst = 0;
  int  cycle_count = 0;
  bit  hold_done  = 1'b0;

  calendar_day_difference_unit #(
    .YEAR_BITS (YEAR_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_first_year      (in_first_year),
    .in_first_month     (in_first_month),
    .in_first_day       (in_first_day),
    .in_second_year     (in_second_year),
    .in_second_month    (in_second_month),
    .in_second_day      (in_second_day),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_day_difference (out_day_difference)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic date_t mk(int y, int m, int d);
    date_t dt;
    dt.year  = YEAR_BITS'(y);
    dt.month = MONTH_W'(m);
    dt.day   = DAY_W'(d);
    return dt;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    else if (r < 80)
      return $urandom_range(1, 2);
    else if (r < 95)
      return $urandom_range(3, 8);
    return $urandom_range(15, 60);
  endfunction

  function automatic int month_len(int y, int m);
    if (m == 2)
      return ((y % 4) == 0) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11)
      return 30;
    return 31;
  endfunction

  function automatic date_t any_date();
    return mk($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31));
  endfunction

  function automatic date_t proper_date(int y);
    int m;
    m = $urandom_range(1, 12);
    return mk(y, m, $urandom_range(1, month_len(y, m)));
  endfunction

  // one input beat, then an optional idle stretch
  task automatic send_dates(date_t measured, date_t reference);
    int gap;
    in_valid        <= 1'b1;
    in_first_year   <= measured.year;
    in_first_month  <= measured.month;
    in_first_day    <= measured.day;
    in_second_year  <= reference.year;
    in_second_month <= reference.month;
    in_second_day   <= reference.day;
    do @(posedge clk); while (!in_ready);
    sb.note_dates(measured, reference);
    beats_in++;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else if ($urandom_range(0, 29) == 0) begin
      send_burst = $urandom_range(20, 80);
      gap = 0;
    end else begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one random date pair, mixing noise with realistic dates
  task automatic send_random_pair();
    int    r;
    int    y;
    int    edges[6] = '{0, 1, 3, 4, 4092, 4095};
    date_t a;
    date_t b;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      a = any_date();
      b = any_date();
    end else if (r < 70) begin
      a = proper_date($urandom_range(0, 4095));
      b = proper_date($urandom_range(0, 4095));
    end else if (r < 85) begin
      y = $urandom_range(1, 4094);
      b = proper_date(y);
      a = proper_date(y + $urandom_range(0, 2) - 1);
    end else if (r < 93) begin
      a = any_date();
      b = a;
    end else begin
      a = mk(edges[$urandom_range(0, 5)], $urandom_range(0, 15), $urandom_range(0, 31));
      b = mk(edges[$urandom_range(0, 5)], $urandom_range(0, 15), $urandom_range(0, 31));
    end
    send_dates(a, b);
  endtask

  // output side: random stalls, quiet stretches and one long hold-off
  task automatic drain_results();
    int stall_left;
    int burst_left;
    stall_left = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_difference(out_day_difference);
      if (!hold_done && beats_in >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && burst_left == 0) begin
        if ($urandom_range(0, 19) == 0)
          burst_left = $urandom_range(20, 80);
        else
          stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (burst_left > 0)
          burst_left--;
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_first_year   <= '0;
    in_first_month  <= '0;
    in_first_day    <= '0;
    in_second_year  <= '0;
    in_second_month <= '0;
    in_second_day   <= '0;
    out_ready       <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      drain_results();
    join_none

    // directed: identical dates, extremes, leap february, odd months and days
    send_dates(mk(2024, 2, 29), mk(2024, 2, 29));
    send_dates(mk(0, 1, 1), mk(0, 1, 1));
    send_dates(mk(4095, 15, 31), mk(0, 0, 0));
    send_dates(mk(0, 0, 0), mk(4095, 15, 31));
    send_dates(mk(4095, 12, 31), mk(0, 1, 1));
    send_dates(mk(2024, 3, 1), mk(2024, 2, 28));
    send_dates(mk(2023, 3, 1), mk(2023, 2, 28));
    send_dates(mk(100, 0, 5), mk(100, 1, 5));
    send_dates(mk(100, 13, 0), mk(101, 1, 0));
    send_dates(mk(2024, 15, 1), mk(2024, 14, 1));
    send_dates(mk(2000, 5, 0), mk(2000, 4, 30));
    send_dates(mk(2001, 2, 31), mk(2001, 3, 3));
    send_dates(mk(4, 1, 1), mk(3, 12, 31));
    send_dates(mk(1, 1, 1), mk(0, 1, 1));
    send_dates(mk(4092, 2, 29), mk(4095, 12, 31));
    send_dates(mk(2048, 12, 31), mk(2048, 1, 1));
    send_dates(mk(3, 3, 1), mk(4, 3, 1));
    send_dates(mk(0, 2, 29), mk(0, 3, 1));
    send_dates(mk(4095, 0, 0), mk(4095, 15, 31));
    send_dates(mk(1, 12, 31), mk(0, 12, 31));
    send_dates(mk(12'hAAA, 10, 21), mk(12'h555, 5, 10));
    send_dates(mk(12'h555, 5, 10), mk(12'hAAA, 10, 21));

    // random part
    repeat (RANDOM_BEATS) send_random_pair();
    in_valid <= 1'b0;

    // wait for every owed result, then idle for DRAIN_CYCLES to catch stray beats
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
